// ----- sv/emboss_3x3_rgb_filter_core_macros.svh -----
// Assertion helpers shared by the emboss filter RTL.
`ifndef EMBOSS_3X3_RGB_FILTER_CORE_MACROS_SVH
`define EMBOSS_3X3_RGB_FILTER_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define EMB_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: invariant violated");

// Same-cycle implication.
`define EMB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// Next-cycle implication.
`define EMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`endif

// ----- sv/emb_pkg.sv -----
`default_nettype none

package emb_pkg;

  // Pixel and channel widths
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  // Configuration register width and geometry width (covers dimensions up to 16383)
  localparam int CFG_W = 12;
  localparam int DIM_W = 14;
  localparam int MIN_DIM = 3;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Emboss arithmetic
  localparam int EMBOSS_BIAS = 128;
  localparam int CH_MAX      = 255;

  // APB port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_req_t;

  typedef struct packed {
    logic            last_of_frame;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
  } pix_res_t;

  // Frame geometry, derived from the frame size registers
  typedef struct packed {
    logic [DIM_W-1:0] used_w;
    logic [DIM_W-1:0] w_last;
    logic [DIM_W-1:0] w_m2;
    logic [DIM_W-1:0] h_last;
    logic [DIM_W-1:0] h_m2;
  } geom_t;

  // Where a result takes its value from
  typedef enum logic [2:0] {
    SEL_EMBOSS,
    SEL_PASS_LEFT,
    SEL_PASS_CENTRE,
    SEL_DRAIN_UPPER,
    SEL_DRAIN_MIDDLE
  } res_sel_t;

  // Decision made for a request at the moment it is accepted
  typedef struct packed {
    logic     is_pixel;
    logic     emit;
    logic     last;
    res_sel_t sel;
  } issue_t;

endpackage

`default_nettype wire

// ----- sv/emb_chan_if.sv -----
`default_nettype none

interface emb_chan_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/emb_cfg.sv -----
`default_nettype none

module emb_cfg #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [emb_pkg::APB_AW-1:0] paddr,
  input  wire logic [emb_pkg::APB_DW-1:0] pwdata,
  output logic      [emb_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output emb_pkg::geom_t                  geom,
  output logic                            restart
);
  import emb_pkg::*;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [CFG_W-1:0] width_next;
  logic [CFG_W-1:0] height_next;
  logic             wr;
  logic             reg_idx;
  geom_t            geom_next;
  geom_t            geom_reset;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] raw,
                                                 input logic [DIM_W-1:0] limit);
    logic [DIM_W-1:0] ext;
    ext = DIM_W'(raw);
    if (ext < DIM_W'(MIN_DIM)) ext = DIM_W'(MIN_DIM);
    if (ext > limit) ext = limit;
    return ext;
  endfunction

  function automatic geom_t calc_geom(input logic [CFG_W-1:0] w_raw,
                                      input logic [CFG_W-1:0] h_raw);
    geom_t            g;
    logic [DIM_W-1:0] uw;
    logic [DIM_W-1:0] uh;
    uw       = clamp_dim(w_raw, DIM_W'(MAX_WIDTH));
    uh       = clamp_dim(h_raw, DIM_W'(MAX_HEIGHT));
    g.used_w = uw;
    g.w_last = uw - DIM_W'(1);
    g.w_m2   = uw - DIM_W'(2);
    g.h_last = uh - DIM_W'(1);
    g.h_m2   = uh - DIM_W'(2);
    return g;
  endfunction

  // APB decode: write lands in the access phase
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  // every write restarts the frame
  assign restart = wr;

  always_comb begin
    width_next  = frame_width;
    height_next = frame_height;
    if (wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  width_next  = pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_next = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom_next  = calc_geom(width_next, height_next);
  assign geom_reset = calc_geom(CFG_W'(RESET_WIDTH), CFG_W'(RESET_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(RESET_WIDTH);
      frame_height <= CFG_W'(RESET_HEIGHT);
      geom         <= geom_reset;
    end else begin
      frame_width  <= width_next;
      frame_height <= height_next;
      geom         <= geom_next;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/emb_line_mem.sv -----
`default_nettype none

module emb_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [emb_pkg::PIX_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [emb_pkg::PIX_W-1:0] rdata
);
  import emb_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_q;
  logic [PIX_W-1:0] byp_data;
  logic             byp;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a write to the same entry in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (re) begin
      rd_q     <= mem[raddr];
      byp      <= we && (waddr == raddr);
      byp_data <= wdata;
    end
  end

  assign rdata = byp ? byp_data : rd_q;

endmodule

`default_nettype wire

// ----- sv/emb_ctrl.sv -----
`default_nettype none

module emb_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int CLW        = 11
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           restart,
  input  wire logic           accept,
  input  wire logic           req_type,
  input  wire emb_pkg::geom_t geom,
  output emb_pkg::issue_t     issue,
  output logic [CLW-1:0]      rd_addr
);
  import emb_pkg::*;
  `include "emboss_3x3_rgb_filter_core_macros.svh"

  localparam int RLW = $clog2(MAX_HEIGHT);
  localparam int PW  = $clog2(MAX_WIDTH + 2);

  logic [RLW-1:0] in_row;
  logic [CLW-1:0] in_col;
  logic [RLW-1:0] out_row;
  logic [CLW-1:0] out_col;
  logic [PW-1:0]  pend;

  logic is_pixel;
  logic in_col_last;
  logic in_row_last;
  logic out_col_last;
  logic out_row_last;
  logic pix_emit;
  logic drain_emit;
  logic interior;
  logic pos_in_frame;

  // Position compares
  assign is_pixel     = (req_type == REQ_PIXEL);
  assign in_col_last  = (DIM_W'(in_col) == geom.w_last);
  assign in_row_last  = (DIM_W'(in_row) == geom.h_last);
  assign out_col_last = (DIM_W'(out_col) == geom.w_last);
  assign out_row_last = (DIM_W'(out_row) == geom.h_last);

  // A pixel emits once a full row plus one is pending; drains only at frame start
  assign pix_emit   = (DIM_W'(pend) > geom.used_w);
  assign drain_emit = (in_row == '0) && (in_col == '0) && (pend != '0);
  assign interior   = (out_row != '0) && (DIM_W'(out_row) <= geom.h_m2) &&
                      (out_col != '0) && (DIM_W'(out_col) <= geom.w_m2);

  // Issue decision
  always_comb begin
    issue.is_pixel = is_pixel;
    issue.emit     = is_pixel ? pix_emit : drain_emit;
    issue.last     = out_row_last && out_col_last;
    if (is_pixel) begin
      if (interior) begin
        issue.sel = SEL_EMBOSS;
      end else if (in_col == '0) begin
        issue.sel = SEL_PASS_LEFT;
      end else begin
        issue.sel = SEL_PASS_CENTRE;
      end
    end else begin
      issue.sel = out_row_last ? SEL_DRAIN_MIDDLE : SEL_DRAIN_UPPER;
    end
    rd_addr = is_pixel ? in_col : out_col;
  end

  // Raster counters and pending count
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      pend    <= '0;
    end else if (accept) begin
      if (is_pixel) begin
        if (in_col_last) begin
          in_col <= '0;
          in_row <= in_row_last ? '0 : in_row + RLW'(1);
        end else begin
          in_col <= in_col + CLW'(1);
        end
      end
      if (issue.emit) begin
        if (out_col_last) begin
          out_col <= '0;
          out_row <= out_row_last ? '0 : out_row + RLW'(1);
        end else begin
          out_col <= out_col + CLW'(1);
        end
      end
      if (is_pixel && !pix_emit) begin
        pend <= pend + PW'(1);
      end else if (!is_pixel && drain_emit) begin
        pend <= pend - PW'(1);
      end
    end
  end

  // Both raster positions stay inside the frame
  assign pos_in_frame = (DIM_W'(in_col) <= geom.w_last) && (DIM_W'(out_col) <= geom.w_last) &&
                        (DIM_W'(in_row) <= geom.h_last) && (DIM_W'(out_row) <= geom.h_last);

  // Checks
  `EMB_ASSERT_ALWAYS(a_pend_bound, clk, rst, DIM_W'(pend) <= geom.used_w + DIM_W'(1))
  `EMB_ASSERT_ALWAYS(a_pos_bound, clk, rst, pos_in_frame)

endmodule

`default_nettype wire

// ----- sv/emb_datapath.sv -----
`default_nettype none

module emb_datapath #(
  parameter int AW = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire emb_pkg::pix_req_t         in_payload,
  output logic                           in_ready,
  input  wire emb_pkg::issue_t           issue,
  input  wire logic [AW-1:0]             rd_addr,
  input  wire logic [emb_pkg::PIX_W-1:0] upper_rdata,
  input  wire logic [emb_pkg::PIX_W-1:0] middle_rdata,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [emb_pkg::PIX_W-1:0]      upper_wdata,
  output logic [emb_pkg::PIX_W-1:0]      middle_wdata,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output emb_pkg::pix_res_t              res_payload
);
  import emb_pkg::*;
  `include "emboss_3x3_rgb_filter_core_macros.svh"

  // Working stage
  logic             s1_valid;
  issue_t           s1_issue;
  logic [PIX_W-1:0] s1_px;
  logic [AW-1:0]    s1_col;

  // Window columns kept between pixels (column 1 = left, column 2 = centre)
  logic [PIX_W-1:0] top_c1;
  logic [PIX_W-1:0] top_c2;
  logic [PIX_W-1:0] mid_c1;
  logic [PIX_W-1:0] mid_c2;
  logic [PIX_W-1:0] bot_c2;

  logic             accept;
  logic             go;
  logic             commit;
  logic [PIX_W-1:0] emb_px;
  logic [PIX_W-1:0] res_px;

  function automatic logic [CH_W-1:0] emboss_ch(input logic [CH_W-1:0] n0,
                                                input logic [CH_W-1:0] n1,
                                                input logic [CH_W-1:0] n2,
                                                input logic [CH_W-1:0] p0,
                                                input logic [CH_W-1:0] p1,
                                                input logic [CH_W-1:0] p2);
    logic [9:0]  pos;
    logic [9:0]  neg;
    logic [10:0] diff;
    pos  = 10'(EMBOSS_BIAS) + 10'(p0) + 10'(p1) + 10'(p2);
    neg  = 10'(n0) + 10'(n1) + 10'(n2);
    diff = {1'b0, pos} - {1'b0, neg};
    if (diff[10]) begin
      return '0;
    end else if (diff[9:0] > 10'(CH_MAX)) begin
      return CH_W'(CH_MAX);
    end else begin
      return diff[CH_W-1:0];
    end
  endfunction

  // Handshake: the stage moves on unless its result would land on a stalled one
  assign go       = !s1_issue.emit || !res_valid || res_ready;
  assign commit   = s1_valid && go;
  assign in_ready = !s1_valid || go;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_issue <= issue;
      s1_px    <= {in_payload.red_in, in_payload.green_in, in_payload.blue_in};
      s1_col   <= rd_addr;
    end
  end

  // Line store update: upper takes the old middle entry, middle takes the pixel
  assign wr_en        = commit && s1_issue.is_pixel;
  assign wr_addr      = s1_col;
  assign upper_wdata  = middle_rdata;
  assign middle_wdata = s1_px;

  // Window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      top_c1 <= '0;
      top_c2 <= '0;
      mid_c1 <= '0;
      mid_c2 <= '0;
      bot_c2 <= '0;
    end else if (wr_en) begin
      top_c1 <= top_c2;
      top_c2 <= upper_rdata;
      mid_c1 <= mid_c2;
      mid_c2 <= middle_rdata;
      bot_c2 <= s1_px;
    end
  end

  // Emboss on the shifted window, per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      emb_px[c*CH_W +: CH_W] = emboss_ch(top_c1[c*CH_W +: CH_W],
                                         top_c2[c*CH_W +: CH_W],
                                         mid_c1[c*CH_W +: CH_W],
                                         middle_rdata[c*CH_W +: CH_W],
                                         bot_c2[c*CH_W +: CH_W],
                                         s1_px[c*CH_W +: CH_W]);
    end
  end

  // Result source
  always_comb begin
    unique case (s1_issue.sel)
      SEL_EMBOSS:       res_px = emb_px;
      SEL_PASS_LEFT:    res_px = mid_c1;
      SEL_PASS_CENTRE:  res_px = mid_c2;
      SEL_DRAIN_UPPER:  res_px = upper_rdata;
      SEL_DRAIN_MIDDLE: res_px = middle_rdata;
      default:          res_px = mid_c2;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit && s1_issue.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && s1_issue.emit) begin
      res_payload.last_of_frame <= s1_issue.last;
      res_payload.red_out       <= res_px[2*CH_W +: CH_W];
      res_payload.green_out     <= res_px[CH_W +: CH_W];
      res_payload.blue_out      <= res_px[0 +: CH_W];
    end
  end

  // Checks
  `EMB_ASSERT_NEXT(a_emit_lands, clk, rst, commit && s1_issue.emit, res_valid)
  `EMB_ASSERT_IMP(a_no_overwrite, clk, rst, res_valid && !res_ready, !(commit && s1_issue.emit))

endmodule

`default_nettype wire

// ----- sv/emboss_3x3_rgb_filter_core.sv -----
// 3x3 emboss filter for a raster stream of blue/green/red pixels.
// request: valid/ready channel; req_type 0 carries a pixel, 1 is a drain tick.
// result:  valid/ready channel; one pixel per result, last_of_frame marks the
//          bottom-right pixel of a frame.
// APB: frame_width at 0x0, frame_height at 0x4 (12 bits each, clamped to
//      3..MAX_WIDTH / 3..MAX_HEIGHT). A write restarts the frame counters;
//      write only while the block is idle.
// Throughput: one request per clock while results are taken. Each line store is
// a memory with one read and one write port per cycle, and the window/emboss
// step sits in a single stage, so a request can enter every cycle.
// Pipeline: a request is registered in the working stage, and its result is
// loaded into the output register when that stage commits. Results trail the
// input by frame_width+1 pixels; after the last pixel of a frame, frame_width+1
// drain ticks flush the rest.
// Reset: counters cleared, frame 640x480. Line stores are not cleared, so no
// clearing pass is needed and requests are taken straight after reset.
// Stall: if result is not taken, requests pass the working stage until one with
// a result is held; request.ready then drops until the output register is taken.
`default_nettype none

module emboss_3x3_rgb_filter_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  emb_chan_if.sink                        request,
  emb_chan_if.source                      result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [emb_pkg::APB_AW-1:0] paddr,
  input  wire logic [emb_pkg::APB_DW-1:0] pwdata,
  output logic      [emb_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import emb_pkg::*;

  localparam int CLW = $clog2(MAX_WIDTH);

  geom_t            geom;
  logic             restart;
  issue_t           issue;
  logic [CLW-1:0]   rd_addr;
  logic             accept;
  logic             wr_en;
  logic [CLW-1:0]   wr_addr;
  logic [PIX_W-1:0] upper_wdata;
  logic [PIX_W-1:0] middle_wdata;
  logic [PIX_W-1:0] upper_rdata;
  logic [PIX_W-1:0] middle_rdata;
  pix_req_t         req_payload;
  pix_res_t         res_payload;

  assign req_payload    = request.payload;
  assign accept         = request.valid && request.ready;
  assign result.payload = res_payload;

  // Configuration registers
  emb_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom),
    .restart (restart)
  );

  // Raster counters and issue decision
  emb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CLW        (CLW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .accept   (accept),
    .req_type (req_payload.req_type),
    .geom     (geom),
    .issue    (issue),
    .rd_addr  (rd_addr)
  );

  // Line stores
  emb_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CLW)
  ) u_upper (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (upper_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (upper_rdata)
  );

  emb_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CLW)
  ) u_middle (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (middle_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (middle_rdata)
  );

  // Window, emboss and output register
  emb_datapath #(
    .AW (CLW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (request.valid),
    .in_payload   (req_payload),
    .in_ready     (request.ready),
    .issue        (issue),
    .rd_addr      (rd_addr),
    .upper_rdata  (upper_rdata),
    .middle_rdata (middle_rdata),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .upper_wdata  (upper_wdata),
    .middle_wdata (middle_wdata),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_payload  (res_payload)
  );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import emb_pkg::*;

  localparam int MAX_W = 2048;
  localparam int MAX_H = 2048;
  localparam int RANDOM_ITEMS = 580;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;

  // Expected-pixel store plus a request-by-request copy of the filter's frame state
  class emboss_scoreboard;
    bit [CFG_W-1:0] width_reg;
    bit [CFG_W-1:0] height_reg;
    bit [PIX_W-1:0] upper_line [MAX_W];
    bit [PIX_W-1:0] middle_line [MAX_W];
    bit [PIX_W-1:0] win [3][3];
    int unsigned in_r, in_c, out_r, out_c;
    pix_res_t expected_pixels [$];
    int unsigned mismatches;

    function new();
      width_reg = CFG_W'(RESET_WIDTH);
      height_reg = CFG_W'(RESET_HEIGHT);
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      mismatches = 0;
    endfunction

    function int unsigned used_w();
      int unsigned v;
      v = int'(width_reg);
      if (v < MIN_DIM) v = MIN_DIM;
      if (v > MAX_W) v = MAX_W;
      return v;
    endfunction

    function int unsigned used_h();
      int unsigned v;
      v = int'(height_reg);
      if (v < MIN_DIM) v = MIN_DIM;
      if (v > MAX_H) v = MAX_H;
      return v;
    endfunction

    // Results still owed: raster distance from output to input position
    function int unsigned backlog();
      int unsigned w, total;
      w = used_w();
      total = w * used_h();
      return (in_r * w + in_c + total - (out_r * w + out_c)) % total;
    endfunction

    // Per-lane emboss over the window, biased and clamped
    function bit [PIX_W-1:0] emboss_px();
      bit [PIX_W-1:0] res;
      int s;
      res = '0;
      for (int sh = 0; sh < PIX_W; sh += CH_W) begin
        s = EMBOSS_BIAS - int'(win[0][0][sh +: CH_W]) - int'(win[0][1][sh +: CH_W])
            - int'(win[1][0][sh +: CH_W]) + int'(win[1][2][sh +: CH_W])
            + int'(win[2][1][sh +: CH_W]) + int'(win[2][2][sh +: CH_W]);
        if (s < 0) s = 0;
        if (s > CH_MAX) s = CH_MAX;
        res[sh +: CH_W] = s[CH_W-1:0];
      end
      return res;
    endfunction

    function void queue_result(bit [PIX_W-1:0] px);
      pix_res_t e;
      int unsigned w, h;
      w = used_w();
      h = used_h();
      e.blue_out = px[CH_W-1:0];
      e.green_out = px[2*CH_W-1:CH_W];
      e.red_out = px[3*CH_W-1:2*CH_W];
      e.last_of_frame = (out_r == h - 1 && out_c == w - 1);
      expected_pixels.push_back(e);
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
        if (out_r >= h) out_r = 0;
      end
    endfunction

    // A register write restarts the frame; line stores survive
    function void write_reg(logic idx, logic [APB_DW-1:0] value);
      if (idx == REG_FRAME_WIDTH) width_reg = value[CFG_W-1:0];
      else height_reg = value[CFG_W-1:0];
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    endfunction

    function void note_request(pix_req_t rq);
      int unsigned w, h, pend, col;
      bit [PIX_W-1:0] px, above2, above1, val;
      w = used_w();
      h = used_h();
      pend = backlog();
      if (rq.req_type == REQ_PIXEL) begin
        px = {rq.red_in, rq.green_in, rq.blue_in};
        col = in_c;
        above2 = upper_line[col];
        above1 = middle_line[col];
        for (int r = 0; r < 3; r++) begin
          win[r][0] = win[r][1];
          win[r][1] = win[r][2];
        end
        win[0][2] = above2;
        win[1][2] = above1;
        win[2][2] = px;
        upper_line[col] = above1;
        middle_line[col] = px;
        in_c++;
        if (in_c >= w) begin
          in_c = 0;
          in_r++;
          if (in_r >= h) in_r = 0;
        end
        // Warm-up: nothing leaves until a row and a pixel are buffered
        if (pend >= w + 1) begin
          if (out_r >= 1 && out_r <= h - 2 && out_c >= 1 && out_c <= w - 2)
            val = emboss_px();
          else if (col == 0)
            val = win[1][0];
          else
            val = win[1][1];
          queue_result(val);
        end
      end else if (in_r == 0 && in_c == 0 && pend > 0) begin
        // Drain: the tail of the frame comes straight from the line stores
        val = (out_r == h - 1) ? middle_line[out_c] : upper_line[out_c];
        queue_result(val);
      end
    endfunction

    function void check_result(pix_res_t got);
      pix_res_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: blue %0d green %0d red %0d last %0d",
               got.blue_out, got.green_out, got.red_out, got.last_of_frame);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.blue_out !== want.blue_out) begin
        $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
        mismatches++;
      end
      if (got.green_out !== want.green_out) begin
        $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
        mismatches++;
      end
      if (got.red_out !== want.red_out) begin
        $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
        mismatches++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        $error("last_of_frame: expected %0d, got %0d", want.last_of_frame,
               got.last_of_frame);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  emb_chan_if #(.payload_t(pix_req_t)) request_ch ();
  emb_chan_if #(.payload_t(pix_res_t)) result_ch ();

  emboss_scoreboard sb = new();

  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 61;
  int unsigned hold_order = 0;

  emboss_3x3_rgb_filter_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .request(request_ch),
    .result (result_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (request_ch.valid && request_ch.ready) sb.note_request(request_ch.payload);
      if (result_ch.valid && result_ch.ready) sb.check_result(result_ch.payload);
    end
  end

  // Result side back-pressure, with one long hold-off
  initial begin
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left = 0;
    hold_served = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_order) begin
        hold_served = hold_order;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [CH_W-1:0] random_channel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(CH_MAX));
    endcase
  endfunction

  function automatic pix_req_t random_pixel();
    pix_req_t rq;
    rq.req_type = REQ_PIXEL;
    rq.blue_in = random_channel();
    rq.green_in = random_channel();
    rq.red_in = random_channel();
    return rq;
  endfunction

  function automatic pix_req_t drain_tick();
    pix_req_t rq;
    rq.req_type = REQ_DRAIN;
    rq.blue_in = CH_W'($urandom_range(CH_MAX));
    rq.green_in = CH_W'($urandom_range(CH_MAX));
    rq.red_in = CH_W'($urandom_range(CH_MAX));
    return rq;
  endfunction

  // 3x3 probe frame: taps pushed to the extremes so the sum clamps high or low
  function automatic pix_req_t probe_pixel(int unsigned pos, bit swap);
    pix_req_t rq;
    logic [CH_W-1:0] up, down;
    if (pos == 5 || pos == 7 || pos == 8) begin
      up = '1;
      down = '0;
    end else if (pos == 0 || pos == 1 || pos == 3) begin
      up = '0;
      down = '1;
    end else begin
      up = CH_W'($urandom_range(CH_MAX));
      down = CH_W'($urandom_range(CH_MAX));
    end
    rq.req_type = REQ_PIXEL;
    rq.blue_in = swap ? down : up;
    rq.green_in = swap ? up : down;
    rq.red_in = CH_W'($urandom_range(CH_MAX));
    return rq;
  endfunction

  task automatic push_request(input pix_req_t rq);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(negedge clk);
    end
    request_ch.valid <= 1'b1;
    request_ch.payload <= rq;
    do @(posedge clk); while (!request_ch.ready);
  endtask

  task automatic send_frame(input int unsigned n_pix, input bit noisy);
    for (int unsigned i = 0; i < n_pix; i++) begin
      // stray drain ticks inside a frame
      if (noisy && $urandom_range(29) == 0) push_request(drain_tick());
      push_request(random_pixel());
    end
  endtask

  task automatic send_drains(input int unsigned n);
    repeat (n) push_request(drain_tick());
  endtask

  // Let the block go idle, then write one register over APB
  task automatic program_reg(input logic idx, input logic [APB_DW-1:0] value);
    @(negedge clk);
    request_ch.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [APB_DW-1:0] pick_width();
    case ($urandom_range(15))
      0: return $urandom_range(0, MIN_DIM - 1);
      1: return $urandom_range(9, 24);
      2: return $urandom_range(3, 8) | ($urandom() << CFG_W);
      default: return $urandom_range(3, 8);
    endcase
  endfunction

  function automatic logic [APB_DW-1:0] pick_height();
    if ($urandom_range(15) == 0) return $urandom_range(0, MIN_DIM - 1);
    return $urandom_range(3, 6);
  endfunction

  initial begin
    int unsigned random_items, w, h, n;
    bit need_restart, pressure_done;
    request_ch.valid = 1'b0;
    request_ch.payload = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    random_items = 0;
    need_restart = 1'b1;
    pressure_done = 1'b0;
    wait (rst === 1'b0);

    // Reset geometry 640x480: just enough pixels to get past the warm-up
    send_frame(645, 1'b0);

    // Smallest frame, written with values below range
    program_reg(REG_FRAME_WIDTH, 32'd0);
    program_reg(REG_FRAME_HEIGHT, 32'd2);
    push_request(drain_tick());
    for (int unsigned pos = 0; pos < 9; pos++) begin
      if (pos == 4) push_request(drain_tick());
      push_request(probe_pixel(pos, 1'b0));
    end
    // back-to-back frame pushes out the tail of the first
    for (int unsigned pos = 0; pos < 9; pos++) push_request(probe_pixel(pos, 1'b1));
    send_drains(5);

    // Random frames, three idling regimes
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_items >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 14;
      end
      if (need_restart || $urandom_range(3) == 0) begin
        program_reg(REG_FRAME_WIDTH, pick_width());
        program_reg(REG_FRAME_HEIGHT, pick_height());
        need_restart = 1'b0;
      end
      w = sb.used_w();
      h = sb.used_h();
      // long result stall while pixels keep coming
      if (recv_idle_pct == 0 && !pressure_done) begin
        hold_order++;
        pressure_done = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        // truncated frame, abandoned by the next register write
        n = $urandom_range(1, w * h - 1);
        send_frame(n, 1'b1);
        random_items += n;
        need_restart = 1'b1;
      end else begin
        send_frame(w * h, 1'b1);
        random_items += w * h;
        if ($urandom_range(1)) begin
          send_drains(w + 1 + $urandom_range(1));
          random_items += w + 1;
        end
      end
    end

    @(negedge clk);
    request_ch.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
